// ===== src/dwpb_pkg.sv =====
package dwpb_pkg;

  localparam int CFG_W      = 8;
  localparam int CNT_W      = 6;
  localparam int SUM_W      = 40;
  localparam int DMAG_W     = 16;
  localparam int SQ_W       = 32;
  localparam int CUBE_W     = 48;
  localparam int PROD_W     = 56;
  localparam int ACC_W      = 59;
  localparam int ROOT_ARG_W = 32;
  localparam int TRIAL_W    = 34;

  localparam logic [2:0] REG_BASE_SPEED = 3'd0;
  localparam logic [2:0] REG_KP_NUM     = 3'd1;
  localparam logic [2:0] REG_KP_DEN     = 3'd2;
  localparam logic [2:0] REG_KI_NUM     = 3'd3;
  localparam logic [2:0] REG_KI_DEN     = 3'd4;
  localparam logic [2:0] REG_KD_NUM     = 3'd5;
  localparam logic [2:0] REG_KD_DEN     = 3'd6;

  localparam logic signed [SUM_W:0] SUM_MAX = 41'sd549755813887;
  localparam logic [DMAG_W-1:0] DIFF_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  typedef struct packed {
    logic             clear;
    logic             load;
    logic             mul;
    term_t            sel;
    logic             div_step;
    logic             root_init;
    logic             root_step;
    logic             acc_div;
    logic             acc_root;
    logic             sq;
    logic             cube;
    logic             finish;
    logic [CNT_W-1:0] step;
  } dwpb_cmd_t;

  typedef struct packed {
    logic out_free;
  } dwpb_sts_t;

endpackage

// ===== src/dwpb_ctrl.sv =====
module dwpb_ctrl
  import dwpb_pkg::*;
#(
  parameter int ROOT_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  output dwpb_cmd_t cmd,
  input  dwpb_sts_t sts
);

  typedef enum logic [14:0] {
    S_IDLE      = 15'b000000000000001,
    S_MUL_P     = 15'b000000000000010,
    S_DIV_P     = 15'b000000000000100,
    S_ACC_P     = 15'b000000000001000,
    S_MUL_I     = 15'b000000000010000,
    S_DIV_I     = 15'b000000000100000,
    S_ROOT_INIT = 15'b000000001000000,
    S_ROOT      = 15'b000000010000000,
    S_ACC_I     = 15'b000000100000000,
    S_SQ        = 15'b000001000000000,
    S_CUBE      = 15'b000010000000000,
    S_MUL_D     = 15'b000100000000000,
    S_DIV_D     = 15'b001000000000000,
    S_ACC_D     = 15'b010000000000000,
    S_FINISH    = 15'b100000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.sel   = TERM_P;
    cmd.step  = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = S_MUL_P;
          end
        end
      end
      S_MUL_P: begin
        cmd.mul   = 1'b1;
        cmd.sel   = TERM_P;
        cnt_nxt   = CNT_W'(PROD_W - 1);
        state_nxt = S_DIV_P;
      end
      S_DIV_P: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_ACC_P;
      end
      S_ACC_P: begin
        cmd.acc_div = 1'b1;
        state_nxt   = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.mul   = 1'b1;
        cmd.sel   = TERM_I;
        cnt_nxt   = CNT_W'(PROD_W - 1);
        state_nxt = S_DIV_I;
      end
      S_DIV_I: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = CNT_W'(ROOT_STEPS - 1);
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_ACC_I;
      end
      S_ACC_I: begin
        cmd.acc_root = 1'b1;
        state_nxt    = S_SQ;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube  = 1'b1;
        state_nxt = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul   = 1'b1;
        cmd.sel   = TERM_D;
        cnt_nxt   = CNT_W'(PROD_W - 1);
        state_nxt = S_DIV_D;
      end
      S_DIV_D: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_ACC_D;
      end
      S_ACC_D: begin
        cmd.acc_div = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/dwpb_dp.sv =====
module dwpb_dp
  import dwpb_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int ROOT_STEPS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [CFG_W-1:0]                cfg_data,
  input  logic signed [POSITION_BITS-1:0] in_left_position,
  input  logic signed [POSITION_BITS-1:0] in_right_position,
  input  dwpb_cmd_t                       cmd,
  output dwpb_sts_t                       sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [6:0]                      out_left_duty,
  output logic [6:0]                      out_right_duty,
  output logic signed [5:0]               out_correction
);

  localparam int E_W    = POSITION_BITS + 1;
  localparam int PREV_W = POSITION_BITS + 2;
  localparam int DIFF_W = POSITION_BITS + 3;
  localparam int RIDX_W = $clog2(ROOT_STEPS);

  logic [6:0]       base_r;
  logic [CFG_W-1:0] kp_num_r, kp_den_r, ki_num_r, ki_den_r, kd_num_r, kd_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= 7'd25;
      kp_num_r <= 8'd7;
      kp_den_r <= 8'd5;
      ki_num_r <= 8'd1;
      ki_den_r <= 8'd1;
      kd_num_r <= 8'd1;
      kd_den_r <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_SPEED: base_r   <= cfg_data[6:0];
        REG_KP_NUM:     kp_num_r <= cfg_data;
        REG_KP_DEN:     kp_den_r <= cfg_data;
        REG_KI_NUM:     ki_num_r <= cfg_data;
        REG_KI_DEN:     ki_den_r <= cfg_data;
        REG_KD_NUM:     kd_num_r <= cfg_data;
        REG_KD_DEN:     kd_den_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- frame load: error, clamped difference, clamped sum
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [PREV_W-1:0] prev_r;
  logic signed [E_W-1:0]    e_r;
  logic [DMAG_W-1:0]        dmag_r;
  logic                     dneg_r;

  logic signed [E_W-1:0]    e_w;
  logic signed [DIFF_W-1:0] diff_w;
  logic signed [SUM_W:0]    sum_w;
  logic signed [SUM_W-1:0]  sum_sat;
  logic [DMAG_W-1:0]        dmag_w;
  logic [DIFF_W-1:0]        diff_abs;

  assign e_w    = E_W'(in_left_position) - E_W'(in_right_position);
  assign diff_w = DIFF_W'(e_w) - DIFF_W'(prev_r);
  assign sum_w  = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(e_w);
  assign diff_abs = diff_w[DIFF_W-1] ? DIFF_W'(-diff_w) : DIFF_W'(diff_w);

  always_comb begin
    if (sum_w > SUM_MAX) begin
      sum_sat = SUM_MAX[SUM_W-1:0];
    end else if (sum_w < -SUM_MAX) begin
      sum_sat = SUM_W'(-SUM_MAX);
    end else begin
      sum_sat = sum_w[SUM_W-1:0];
    end
    if (diff_abs > DIFF_W'(DIFF_MAX)) begin
      dmag_w = DIFF_MAX;
    end else begin
      dmag_w = diff_abs[DMAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      prev_r <= '0;
    end else if (cmd.clear) begin
      sum_r  <= '0;
      prev_r <= '0;
    end else if (cmd.load) begin
      sum_r  <= sum_sat;
      prev_r <= PREV_W'(e_w);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r    <= e_w;
      dmag_r <= dmag_w;
      dneg_r <= diff_w[DIFF_W-1];
    end
  end

  // ---- products, shared serial divider, root, accumulator
  logic [PROD_W-1:0]     prod_r;
  logic [8:0]            rem_r;
  logic [CFG_W-1:0]      den_r;
  logic                  neg_r;
  logic [SQ_W-1:0]       sq_r;
  logic [ROOT_ARG_W-1:0] rrem_r;
  logic [ROOT_STEPS-1:0] g_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [E_W-1:0]     e_mag;
  logic [SUM_W-1:0]   sum_mag;
  logic [CFG_W-1:0]   num_sel, den_sel;
  logic               neg_sel;
  logic [PROD_W-1:0]  mul_w;
  logic [8:0]         rsh;
  logic               div_ge;
  logic [RIDX_W-1:0]  ridx;
  logic [TRIAL_W-1:0] bit_w, trial_w;
  logic               root_ge;
  logic [ACC_W-1:0]   qterm, gterm;

  assign e_mag   = e_r[E_W-1] ? E_W'(-e_r) : E_W'(e_r);
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_comb begin
    case (cmd.sel)
      TERM_P: begin
        num_sel = kp_num_r;
        den_sel = kp_den_r;
        neg_sel = e_r[E_W-1];
        mul_w   = PROD_W'(num_sel * (CFG_W + E_W)'(e_mag));
      end
      TERM_I: begin
        num_sel = ki_num_r;
        den_sel = ki_den_r;
        neg_sel = sum_r[SUM_W-1];
        mul_w   = PROD_W'(num_sel * (CFG_W + SUM_W)'(sum_mag));
      end
      TERM_D: begin
        num_sel = kd_num_r;
        den_sel = kd_den_r;
        neg_sel = dneg_r;
        mul_w   = PROD_W'(num_sel) * PROD_W'(prod_r[CUBE_W-1:0]);
      end
      default: begin
        num_sel = '0;
        den_sel = 8'd1;
        neg_sel = 1'b0;
        mul_w   = '0;
      end
    endcase
  end

  assign rsh    = {rem_r[7:0], prod_r[PROD_W-1]};
  assign div_ge = rsh >= {1'b0, den_r};

  assign ridx    = cmd.step[RIDX_W-1:0];
  assign bit_w   = TRIAL_W'(1) << ridx;
  assign trial_w = ((TRIAL_W'(g_r) << 1) | bit_w) << ridx;
  assign root_ge = TRIAL_W'(rrem_r) >= trial_w;

  assign qterm = ACC_W'(prod_r);
  assign gterm = ACC_W'(g_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.acc_div) begin
      acc_r <= neg_r ? acc_r - $signed(qterm) : acc_r + $signed(qterm);
    end else if (cmd.acc_root) begin
      acc_r <= neg_r ? acc_r - $signed(gterm) : acc_r + $signed(gterm);
    end
    if (cmd.mul) begin
      prod_r <= mul_w;
      rem_r  <= '0;
      den_r  <= (den_sel == '0) ? CFG_W'(1) : den_sel;
      neg_r  <= neg_sel;
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? rsh - {1'b0, den_r} : rsh;
      prod_r <= {prod_r[PROD_W-2:0], div_ge};
    end else if (cmd.cube) begin
      prod_r <= PROD_W'(CUBE_W'(sq_r) * CUBE_W'(dmag_r));
    end
    if (cmd.sq) begin
      sq_r <= SQ_W'(dmag_r) * SQ_W'(dmag_r);
    end
    if (cmd.root_init) begin
      rrem_r <= (|prod_r[PROD_W-1:ROOT_ARG_W]) ? '1 : prod_r[ROOT_ARG_W-1:0];
      g_r    <= '0;
    end else if (cmd.root_step && root_ge) begin
      rrem_r <= ROOT_ARG_W'(TRIAL_W'(rrem_r) - trial_w);
      g_r    <= g_r | ROOT_STEPS'(bit_w);
    end
  end

  // ---- output stage
  logic [14:0]             lim_prod;
  logic [4:0]              lim_w;
  logic signed [ACC_W-1:0] lim_s;
  logic signed [5:0]       sig_w;
  logic signed [8:0]       left_w, right_w;
  logic [6:0]              left_duty, right_duty;
  logic                    out_valid_r;

  // base/5 by reciprocal, exact over the 7-bit range
  assign lim_prod = 15'(base_r) * 15'd205;
  assign lim_w    = lim_prod[14:10];
  assign lim_s    = $signed(ACC_W'(lim_w));

  always_comb begin
    if (acc_r > lim_s) begin
      sig_w = $signed(6'(lim_w));
    end else if (acc_r < -lim_s) begin
      sig_w = -$signed(6'(lim_w));
    end else begin
      sig_w = acc_r[5:0];
    end
    left_w  = $signed({2'b00, base_r}) - 9'(sig_w);
    right_w = $signed({2'b00, base_r}) + 9'(sig_w);
    left_duty  = left_w[8] ? 7'd0 : left_w[6:0];
    right_duty = (right_w > 9'sd127) ? 7'd127 : right_w[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_left_duty  <= left_duty;
      out_right_duty <= right_duty;
      out_correction <= sig_w;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || out_ready;

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (sum_r == '0) && (prev_r == '0))
    else $error("start word did not clear stored state");

  a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !(sum_r[SUM_W-1] && (sum_r[SUM_W-2:0] == '0)))
    else $error("error sum escaped its limit");

  a_corr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_correction <= 6'sd25) && (out_correction >= -6'sd25))
    else $error("correction outside one fifth of base speed");

endmodule

// ===== src/differential_wheel_pid_balance.sv =====
// Differential-drive wheel balance PID. Each control word gives left and right
// wheel angles; the block returns both duty cycles and the clamped correction
// (proportional + signed root of integral + cubic derivative). A start word
// (action = 1) clears the error sum and previous error and returns nothing.
// One serial divider, one quotient bit per cycle over 56 bits, serves all
// three terms, and a bitwise square root of ROOT_STEPS result bits follows
// the integral division; a control word may also wait on a busy output.
// One word is in work at a time; a new word is taken while a finished
// result still waits on the output register.
module differential_wheel_pid_balance
  import dwpb_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int ROOT_STEPS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [CFG_W-1:0]                cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic signed [POSITION_BITS-1:0] in_left_position,
  input  logic signed [POSITION_BITS-1:0] in_right_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [6:0]                      out_left_duty,
  output logic [6:0]                      out_right_duty,
  output logic signed [5:0]               out_correction
);

  dwpb_cmd_t cmd;
  dwpb_sts_t sts;

  dwpb_ctrl #(
    .ROOT_STEPS(ROOT_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dwpb_dp #(
    .POSITION_BITS(POSITION_BITS),
    .ROOT_STEPS   (ROOT_STEPS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_left_position (in_left_position),
    .in_right_position(in_right_position),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_duty    (out_left_duty),
    .out_right_duty   (out_right_duty),
    .out_correction   (out_correction)
  );

endmodule
